// ----- sv/rtt_pkg.sv -----
// ---------------------------------------------------------------------------
// Relay transmission tracker package
// Shared types, constants and control structs for the tracker core.
// ---------------------------------------------------------------------------
package rtt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
	localparam int CNT_W       = (CNT_BITS > 5) ? CNT_BITS : 5;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [15:0] WINDOW_RESET = 16'd3;
	localparam logic [15:0] STALE_RESET  = 16'd2;

	typedef enum logic {
		REG_WINDOW = 1'b0,
		REG_STALE  = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_RECORD = 2'd0,
		OP_QUERY  = 2'd1,
		OP_AGE    = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] node_id;
		logic [31:0] packet_id;
		logic [15:0] time_secs;
	} in_item_t;

	typedef struct packed {
		logic       transmitted;
		logic [4:0] entry_count;
	} out_item_t;

	typedef struct packed {
		logic [31:0] sender_id;
		logic [31:0] packet_id;
		logic [15:0] stamp;
	} entry_t;

	typedef struct packed {
		logic [15:0] window_limit_secs;
		logic [15:0] stale_limit_secs;
	} cfg_t;

	typedef enum logic [1:0] {
		WA_IDX   = 2'd0,
		WA_COUNT = 2'd1,
		WA_PICK  = 2'd2
	} waddr_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_REC_RD,
		S_REC_EV,
		S_REP_RD,
		S_REP_EV,
		S_QRY_RD,
		S_QRY_EV,
		S_AGE_RD,
		S_AGE_EV,
		S_AGE_MV,
		S_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic   load;
		logic   rd_en;
		logic   rd_last;
		logic   wr_en;
		logic   wr_from_rd;
		waddr_t wr_addr;
		logic   idx_clr;
		logic   idx_inc;
		logic   cnt_inc;
		logic   cnt_dec;
		logic   pick_eval;
		logic   ans_eval;
		logic   out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  op;
		logic idx_end;
		logic scan_end;
		logic full;
		logic node_hit;
		logic pkt_hit;
		logic stale;
		logic idx_below_last;
	} sts_t;

endpackage

// ----- sv/rtt_cfg.sv -----
// ---------------------------------------------------------------------------
// Relay transmission tracker configuration registers
// APB-style register file holding the window and stale limits.
// ---------------------------------------------------------------------------
module rtt_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rtt_pkg::PADDR_W-1:0] paddr,
	input  logic [rtt_pkg::PDATA_W-1:0] pwdata,
	output logic [rtt_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output rtt_pkg::cfg_t               cfg
);
	import rtt_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_stb;

	assign reg_idx = reg_idx_t'(paddr[2]);
	assign pready  = 1'b1;
	assign wr_stb  = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_limit_secs <= WINDOW_RESET;
			cfg_q.stale_limit_secs  <= STALE_RESET;
		end else if (wr_stb) begin
			unique case (reg_idx)
				REG_WINDOW: cfg_q.window_limit_secs <= pwdata[15:0];
				REG_STALE:  cfg_q.stale_limit_secs  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_WINDOW: prdata = {{(PDATA_W-16){1'b0}}, cfg_q.window_limit_secs};
			REG_STALE:  prdata = {{(PDATA_W-16){1'b0}}, cfg_q.stale_limit_secs};
			default:    prdata = '0;
		endcase
	end

endmodule

// ----- sv/rtt_datapath.sv -----
// ---------------------------------------------------------------------------
// Relay transmission tracker datapath
// Entry table, scan index, entry count, replacement pick and result register.
// ---------------------------------------------------------------------------
module rtt_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  rtt_pkg::in_item_t  item,
	input  rtt_pkg::cfg_t      cfg,
	input  rtt_pkg::cmd_t      cmd,
	output rtt_pkg::sts_t      sts,
	output rtt_pkg::out_item_t result
);
	import rtt_pkg::*;

	entry_t           tbl_q [TABLE_DEPTH];
	entry_t           rd_q;
	in_item_t         req_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] pick_q;
	logic [15:0]      pick_age_q;
	logic             answer_q;
	out_item_t        result_q;

	logic [15:0]      age;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	logic [CNT_W-1:0] last;
	entry_t           wr_data;
	logic [CNT_W:0]   idx_next_ext;

	assign age          = req_q.time_secs - rd_q.stamp;
	assign last         = count_q - CNT_W'(1);
	assign idx_next_ext = {1'b0, idx_q} + {{CNT_W{1'b0}}, 1'b1};
	assign rd_addr      = cmd.rd_last ? last[IDX_W-1:0] : idx_q[IDX_W-1:0];

	always_comb begin
		unique case (cmd.wr_addr)
			WA_IDX:   wr_addr = idx_q[IDX_W-1:0];
			WA_COUNT: wr_addr = count_q[IDX_W-1:0];
			WA_PICK:  wr_addr = pick_q;
			default:  wr_addr = idx_q[IDX_W-1:0];
		endcase
	end

	always_comb begin
		if (cmd.wr_from_rd) begin
			wr_data = rd_q;
		end else begin
			wr_data.sender_id = req_q.node_id;
			wr_data.packet_id = req_q.packet_id;
			wr_data.stamp     = req_q.time_secs;
		end
	end

	// Table memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			tbl_q[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= tbl_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= item;
		end
		if (cmd.out_load) begin
			result_q.transmitted <= answer_q;
			result_q.entry_count <= count_q[4:0];
		end
		if (cmd.load) begin
			pick_q     <= '0;
			pick_age_q <= '0;
		end else if (cmd.pick_eval && (idx_q == '0 || age > pick_age_q)) begin
			pick_q     <= idx_q[IDX_W-1:0];
			pick_age_q <= age;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			count_q  <= '0;
			answer_q <= 1'b0;
		end else begin
			if (cmd.load || cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_next_ext[CNT_W-1:0];
			end
			if (cmd.cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.load) begin
				answer_q <= 1'b0;
			end else if (cmd.ans_eval) begin
				answer_q <= (age <= cfg.window_limit_secs);
			end
		end
	end

	assign sts.op             = op_t'(req_q.operation);
	assign sts.idx_end        = (idx_q == count_q);
	assign sts.scan_end       = (idx_q == CNT_W'(TABLE_DEPTH));
	assign sts.full           = (count_q == CNT_W'(TABLE_DEPTH));
	assign sts.node_hit       = (rd_q.sender_id == req_q.node_id);
	assign sts.pkt_hit        = (rd_q.packet_id == req_q.packet_id);
	assign sts.stale          = (age > cfg.stale_limit_secs);
	assign sts.idx_below_last = (idx_next_ext < {1'b0, count_q});

	assign result = result_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count exceeds table depth");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= count_q)
		else $error("scan index passed the entry count");

	a_no_grow_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> count_q < CNT_W'(TABLE_DEPTH))
		else $error("append into a full table");

endmodule

// ----- sv/rtt_ctrl.sv -----
// ---------------------------------------------------------------------------
// Relay transmission tracker controller
// Sequences the table scans for record, query and age, and the result handoff.
// ---------------------------------------------------------------------------
module rtt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	output logic          result_valid,
	input  logic          result_stall,
	input  rtt_pkg::sts_t sts,
	output rtt_pkg::cmd_t cmd
);
	import rtt_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free     = !out_valid_q || !result_stall;
	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE:     if (item_valid) state_nxt = S_DISPATCH;
			S_DISPATCH: begin
				unique case (sts.op)
					OP_RECORD: state_nxt = S_REC_RD;
					OP_QUERY:  state_nxt = S_QRY_RD;
					OP_AGE:    state_nxt = S_AGE_RD;
					default:   state_nxt = S_DONE;
				endcase
			end
			S_REC_RD: begin
				if (!sts.idx_end)   state_nxt = S_REC_EV;
				else if (!sts.full) state_nxt = S_DONE;
				else                state_nxt = S_REP_RD;
			end
			S_REC_EV: state_nxt = sts.node_hit ? S_DONE : S_REC_RD;
			S_REP_RD: state_nxt = sts.scan_end ? S_DONE : S_REP_EV;
			S_REP_EV: state_nxt = S_REP_RD;
			S_QRY_RD: state_nxt = sts.idx_end ? S_DONE : S_QRY_EV;
			S_QRY_EV: state_nxt = (sts.node_hit && sts.pkt_hit) ? S_DONE : S_QRY_RD;
			S_AGE_RD: state_nxt = sts.idx_end ? S_DONE : S_AGE_EV;
			S_AGE_EV: state_nxt = (sts.stale && sts.idx_below_last) ? S_AGE_MV : S_AGE_RD;
			S_AGE_MV: state_nxt = S_AGE_RD;
			S_DONE:   if (out_free) state_nxt = S_IDLE;
			default:  state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.wr_addr = WA_IDX;
		unique case (state_q)
			S_IDLE:     cmd.load = item_valid;
			S_DISPATCH: ;
			S_REC_RD: begin
				if (!sts.idx_end) begin
					cmd.rd_en = 1'b1;
				end else if (!sts.full) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_addr = WA_COUNT;
					cmd.cnt_inc = 1'b1;
				end else begin
					cmd.idx_clr = 1'b1;
				end
			end
			S_REC_EV: begin
				if (sts.node_hit) cmd.wr_en = 1'b1;
				else              cmd.idx_inc = 1'b1;
			end
			S_REP_RD: begin
				if (sts.scan_end) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_addr = WA_PICK;
				end else begin
					cmd.rd_en = 1'b1;
				end
			end
			S_REP_EV: begin
				cmd.pick_eval = 1'b1;
				cmd.idx_inc   = 1'b1;
			end
			S_QRY_RD: cmd.rd_en = !sts.idx_end;
			S_QRY_EV: begin
				if (sts.node_hit && sts.pkt_hit) cmd.ans_eval = 1'b1;
				else                             cmd.idx_inc  = 1'b1;
			end
			S_AGE_RD: cmd.rd_en = !sts.idx_end;
			S_AGE_EV: begin
				// A stale entry is replaced by the last one, which is then checked in turn; a stale last entry is simply dropped.
				if (sts.stale && sts.idx_below_last) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_last = 1'b1;
				end else if (sts.stale) begin
					cmd.cnt_dec = 1'b1;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_AGE_MV: begin
				cmd.wr_en      = 1'b1;
				cmd.wr_from_rd = 1'b1;
				cmd.cnt_dec    = 1'b1;
			end
			S_DONE:  cmd.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> state_q == S_DISPATCH)
		else $error("accepted item did not start processing");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && result_stall))
		else $error("result overwritten while stalled");

	a_single_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_from_rd |-> (cmd.wr_en && $past(cmd.rd_last)))
		else $error("entry move without a read of the last entry");

endmodule

// ----- sv/relay_transmission_tracker_core.sv -----
// ---------------------------------------------------------------------------
// Relay transmission tracker core
// Tracks the last packet and time stamp per sending node in a small table.
// A record into a full table scans it twice, once for the node and once to pick the
// oldest entry to replace; an age adds a move for each removed entry that the last
// entry replaces. One item is in work at a time; the next is taken the cycle after
// the result is registered.
// Reset clears the entry count and control state and restores the limits (window 3, stale 2).
// ---------------------------------------------------------------------------
module relay_transmission_tracker_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  rtt_pkg::in_item_t           item,
	output logic                        result_valid,
	input  logic                        result_stall,
	output rtt_pkg::out_item_t          result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rtt_pkg::PADDR_W-1:0] paddr,
	input  logic [rtt_pkg::PDATA_W-1:0] pwdata,
	output logic [rtt_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import rtt_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	rtt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rtt_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	rtt_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

endmodule
